/* design/sldm_pkg.sv */
// Shared types, constants and helpers for the sine LFO depth modulator.
// No dependencies; imported by every module of the block.
package sldm_pkg;

	localparam int PHASE_W   = 32;
	localparam int LEVEL_W   = 16;
	localparam int RATE_W    = 8;
	localparam int DEPTH_W   = 7;
	localparam int SRATE_W   = 20;
	localparam int CFG_IDX_W = 2;
	localparam int MUL_W     = 32;
	localparam int PROD_W    = 2 * MUL_W;

	// phase divider: numerator rate*count, denominator 100 times the audio rate
	localparam int NUM_W     = 24;
	localparam int DEN_W     = 27;
	localparam int DIV_STEPS = NUM_W + PHASE_W;
	localparam int DIV_CNT_W = 6;

	localparam int X_W    = 31;
	localparam int LFO_W  = LEVEL_W + 1;
	localparam int GAIN_W = 23;
	localparam int Y_W    = 23;

	localparam logic [X_W-1:0]    Q30_ONE    = 31'h4000_0000;
	localparam logic [LFO_W-1:0]  LEVEL_ONE  = 17'h1_0000;
	localparam logic [GAIN_W-1:0] GAIN_FULL  = 23'd6553600;
	localparam logic [23:0]       RECIP_100  = 24'd10737419;
	localparam logic [31:0]       ROUND_HALF = 32'd8192;

	localparam logic [RATE_W-1:0]  RATE_MIN    = 8'd1;
	localparam logic [RATE_W-1:0]  RATE_MAX    = 8'd200;
	localparam logic [RATE_W-1:0]  RATE_RST    = 8'd100;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 7'd100;
	localparam logic [DEPTH_W-1:0] DEPTH_RST   = 7'd0;
	localparam logic [SRATE_W-1:0] SRATE_RST   = 20'd48000;

	localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRATE = 2'd2;

	localparam logic [X_W-1:0] COEF_A1 = 31'd1686629713;
	localparam logic [X_W-1:0] COEF_A3 = 31'd693598668;
	localparam logic [X_W-1:0] COEF_A5 = 31'd85569306;
	localparam logic [X_W-1:0] COEF_A7 = 31'd5026995;
	localparam logic [X_W-1:0] COEF_A9 = 31'd172272;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WB,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NUM,
		OP_X2,
		OP_T7,
		OP_T5,
		OP_T3,
		OP_T1,
		OP_S,
		OP_DG,
		OP_P,
		OP_Q
	} op_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic [PHASE_W-1:0] quot;
	} div_rsp_t;

	function automatic logic [X_W-1:0] poly_coef(input op_t op);
		logic [X_W-1:0] c;
		unique case (op)
			OP_T7:   c = COEF_A7;
			OP_T5:   c = COEF_A5;
			OP_T3:   c = COEF_A3;
			OP_T1:   c = COEF_A1;
			default: c = COEF_A9;
		endcase
		return c;
	endfunction

	function automatic op_t next_op(input op_t op);
		op_t n;
		unique case (op)
			OP_NUM:  n = OP_X2;
			OP_X2:   n = OP_T7;
			OP_T7:   n = OP_T5;
			OP_T5:   n = OP_T3;
			OP_T3:   n = OP_T1;
			OP_T1:   n = OP_S;
			OP_S:    n = OP_DG;
			OP_DG:   n = OP_P;
			OP_P:    n = OP_Q;
			default: n = OP_Q;
		endcase
		return n;
	endfunction

endpackage

/* design/sldm_mul.sv */
// Shared 32x32 multiplier with registered product.
// Depends on sldm_pkg.
module sldm_mul import sldm_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

/* design/sldm_div.sv */
// Restoring divider, one quotient bit per cycle, for the phase increment.
// Keeps the low PHASE_W bits of floor(num * 2^PHASE_W / den). Depends on sldm_pkg.
module sldm_div import sldm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     dvd_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [PHASE_W-1:0]   quot_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	always_comb begin
		trial = {rem_q, dvd_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[NUM_W-2:0], 1'b0};
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quot_q <= {quot_q[PHASE_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quot = quot_q;

endmodule

/* design/sine_lfo_depth_modulator.sv */
// Sine LFO depth modulator: one item per audio block gives the raised sine of the
// current phase and the depth-scaled level, then advances the phase; with a zero
// sample rate the sine and the phase update are skipped and the LFO level is one.
// A result is presented once the 56-step restoring divider for the phase increment
// has finished and the output is free, with the sine polynomial and level scaling
// run on one shared multiplier meanwhile; the divider is not run at zero sample rate.
// A new item is taken once the previous one has reached the output register.
// Depends on sldm_pkg, sldm_mul and sldm_div.
module sine_lfo_depth_modulator import sldm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // block_samples[15:0], max_level[31:16]
	input  logic                 s_tuser,   // restart
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // lfo_level[16:0], modulated_level[32:17]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [SRATE_W-1:0]   cfg_wdata
);

	state_t state_q, state_d;
	op_t    op_q;

	logic [RATE_W-1:0]  rate_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [SRATE_W-1:0] srate_q;
	logic [PHASE_W-1:0] phase_q;

	logic [15:0]        samples_q;
	logic [15:0]        max_level_q;
	logic               quad_hi_q;
	logic [X_W-1:0]     x_q;
	logic [X_W-1:0]     x2_q;
	logic [X_W-1:0]     t_q;
	logic [LFO_W-1:0]   lfo_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [Y_W-1:0]     y_q;
	logic [15:0]        mod_q;
	logic [LFO_W-1:0]   lfo_out_q;
	logic [15:0]        mod_out_q;
	logic               m_tvalid_q;

	logic               srate_zero;
	logic               accept;
	logic               out_free;
	logic               out_load;
	logic               mul_en;
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [PROD_W-1:0]  prod;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic [PHASE_W-1:0] ph_start;
	logic [X_W-1:0]     x_start;
	logic [RATE_W-1:0]  rate_wr;
	logic [DEPTH_W-1:0] depth_wr;
	logic [33:0]        s_raw;
	logic [X_W-1:0]     s_sat;
	logic [31:0]        v_sum;
	logic [31:0]        v_rnd;
	logic [31:0]        t_new;

	sldm_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	sldm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign srate_zero = (srate_q == '0);
	assign out_free   = !m_tvalid_q || m_tready;
	assign accept     = s_tvalid && s_tready;

	// configuration saturation
	always_comb begin
		rate_wr = cfg_wdata[RATE_W-1:0];
		if (rate_wr < RATE_MIN) begin
			rate_wr = RATE_MIN;
		end else if (rate_wr > RATE_MAX) begin
			rate_wr = RATE_MAX;
		end
		depth_wr = cfg_wdata[DEPTH_W-1:0];
		if (depth_wr > DEPTH_MAX) begin
			depth_wr = DEPTH_MAX;
		end
	end

	// quadrant folding of the starting phase
	always_comb begin
		ph_start = s_tuser ? '0 : phase_q;
		x_start  = {1'b0, ph_start[PHASE_W-3:0]};
		if (ph_start[PHASE_W-2]) begin
			x_start = Q30_ONE - x_start;
		end
	end

	// multiplier operand select
	always_comb begin
		unique case (op_q)
			OP_NUM: begin
				mul_a = MUL_W'(rate_q);
				mul_b = MUL_W'(samples_q);
			end
			OP_X2: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(x_q);
			end
			OP_T7, OP_T5, OP_T3, OP_T1: begin
				mul_a = MUL_W'(t_q);
				mul_b = MUL_W'(x2_q);
			end
			OP_S: begin
				mul_a = MUL_W'(t_q);
				mul_b = MUL_W'(x_q);
			end
			OP_DG: begin
				mul_a = MUL_W'(depth_q);
				mul_b = MUL_W'(LEVEL_ONE - lfo_q);
			end
			OP_P: begin
				mul_a = MUL_W'(max_level_q);
				mul_b = MUL_W'(gain_q);
			end
			OP_Q: begin
				mul_a = MUL_W'(y_q);
				mul_b = MUL_W'(RECIP_100);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// write-back arithmetic
	always_comb begin
		t_new = 32'(poly_coef(op_q)) - prod[61:30];
		s_raw = prod[63:30];
		s_sat = (s_raw > 34'(Q30_ONE)) ? Q30_ONE : s_raw[X_W-1:0];
		v_sum = quad_hi_q ? 32'(Q30_ONE) - 32'(s_sat) : 32'(Q30_ONE) + 32'(s_sat);
		v_rnd = {1'b0, v_sum[31:1]} + ROUND_HALF;
	end

	always_comb begin
		div_req.num = prod[NUM_W-1:0];
		div_req.den = (DEN_W'(srate_q) << 6) + (DEN_W'(srate_q) << 5)
			+ (DEN_W'(srate_q) << 2);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				state_d = (op_q == OP_Q) ? ST_DRAIN : ST_ISSUE;
			end
			ST_DRAIN: begin
				if (!div_rsp.busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		mul_en        = (state_q == ST_ISSUE);
		div_req.start = (state_q == ST_WB) && (op_q == OP_NUM) && !srate_zero;
		out_load      = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_NUM;
			rate_q     <= RATE_RST;
			depth_q    <= DEPTH_RST;
			srate_q    <= SRATE_RST;
			phase_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_RATE:  rate_q  <= rate_wr;
					REG_DEPTH: depth_q <= depth_wr;
					REG_SRATE: srate_q <= cfg_wdata;
					default:   ;
				endcase
			end
			if (accept) begin
				op_q <= OP_NUM;
				if (s_tuser) begin
					phase_q <= '0;
				end
			end else if (state_q == ST_WB) begin
				op_q <= (op_q == OP_NUM && srate_zero) ? OP_DG : next_op(op_q);
			end
			if (out_load && !srate_zero) begin
				phase_q <= phase_q + div_rsp.quot;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			samples_q   <= s_tdata[15:0];
			max_level_q <= s_tdata[31:16];
			quad_hi_q   <= ph_start[PHASE_W-1];
			x_q         <= x_start;
			t_q         <= COEF_A9;
			lfo_q       <= LEVEL_ONE;
		end else if (state_q == ST_WB) begin
			unique case (op_q)
				OP_X2:                      x2_q   <= prod[60:30];
				OP_T7, OP_T5, OP_T3, OP_T1: t_q    <= t_new[X_W-1:0];
				OP_S:                       lfo_q  <= v_rnd[30:14];
				OP_DG:                      gain_q <= GAIN_FULL - prod[GAIN_W-1:0];
				OP_P:                       y_q    <= prod[38:16];
				OP_Q:                       mod_q  <= prod[45:30];
				default:                    ;
			endcase
		end
		if (out_load) begin
			lfo_out_q <= lfo_q;
			mod_out_q <= mod_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, mod_out_q, lfo_out_q};

`ifndef SYNTH
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !div_rsp.busy)
		else $error("result formed while divider still busy");

	a_lfo_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WB && op_q == OP_S |=> lfo_q <= LEVEL_ONE)
		else $error("raised sine above one");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WB && op_q == OP_DG |-> prod <= PROD_W'(GAIN_FULL))
		else $error("depth term exceeds full gain");

	a_poly_sign: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WB && (op_q == OP_T7 || op_q == OP_T5 || op_q == OP_T3
		|| op_q == OP_T1) |-> prod[61:30] <= 32'(poly_coef(op_q)))
		else $error("polynomial term went negative");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_DONE && !accept |=> $stable(phase_q))
		else $error("phase changed mid item");
`endif

endmodule
